// ===== rtl/dnsd_pkg.sv =====
// ============================================================================
// DNS name decompressor package
// Shared widths, codes, microcode types and the control program ROM.
// ============================================================================
package dnsd_pkg;

    // Field widths fixed by the interface.
    localparam int ADDR_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int CHARS_W = 64;
    localparam int CNT_W   = 4;
    localparam int NOFF_W  = 10;
    localparam int LEN_W   = 8;
    localparam int ST_W    = 3;
    localparam int HOPS_W  = 5;
    localparam int LANES   = 8;
    localparam int PTR_W   = 14;

    // Command codes.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_RESERVED = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_HOPS     = 3'd3;
    localparam logic [ST_W-1:0] ST_LONG     = 3'd4;

    // Label byte decoding constants.
    localparam logic [BYTE_W-1:0] TYPE_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] LEN_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;

    // Reset value of the hop limit register.
    localparam logic [HOPS_W-1:0] HOPS_RESET = 5'd8;

    // Program counter of the sequencer.
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_LEN,
        STEP_PTR,
        STEP_DOT,
        STEP_CHAR,
        STEP_FINISH
    } t_step;

    // Datapath action selected by the control word.
    typedef enum logic [2:0] {
        ACT_WAIT_CMD,
        ACT_PARSE_LEN,
        ACT_LOAD_PTR,
        ACT_EMIT_DOT,
        ACT_EMIT_CHAR,
        ACT_EMIT_LAST
    } t_act;

    // Branch outcome reported by the datapath.
    typedef enum logic [1:0] {
        BR_HOLD,
        BR_NEXT,
        BR_ALT,
        BR_STOP
    } t_br;

    // One control word: action, sequential target, alternate and stop targets.
    typedef struct packed {
        t_act  act;
        t_step nxt;
        t_step alt;
        t_step stp;
    } t_uword;

    // Control program.
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        w = '{act: ACT_WAIT_CMD, nxt: STEP_IDLE, alt: STEP_IDLE, stp: STEP_IDLE};
        case (pc)
            STEP_IDLE:   w = '{act: ACT_WAIT_CMD,  nxt: STEP_LEN,
                               alt: STEP_IDLE,     stp: STEP_IDLE};
            STEP_LEN:    w = '{act: ACT_PARSE_LEN, nxt: STEP_DOT,
                               alt: STEP_PTR,      stp: STEP_FINISH};
            STEP_PTR:    w = '{act: ACT_LOAD_PTR,  nxt: STEP_LEN,
                               alt: STEP_LEN,      stp: STEP_FINISH};
            STEP_DOT:    w = '{act: ACT_EMIT_DOT,  nxt: STEP_CHAR,
                               alt: STEP_CHAR,     stp: STEP_FINISH};
            STEP_CHAR:   w = '{act: ACT_EMIT_CHAR, nxt: STEP_LEN,
                               alt: STEP_LEN,      stp: STEP_FINISH};
            STEP_FINISH: w = '{act: ACT_EMIT_LAST, nxt: STEP_IDLE,
                               alt: STEP_IDLE,     stp: STEP_IDLE};
            default:     w = '{act: ACT_WAIT_CMD,  nxt: STEP_IDLE,
                               alt: STEP_IDLE,     stp: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/dnsd_store.sv =====
// ============================================================================
// DNS message store
// Single write port and one registered read port over the message bytes.
// ============================================================================
module dnsd_store #(
    parameter int DEPTH = 512
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [dnsd_pkg::BYTE_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [dnsd_pkg::BYTE_W-1:0] o_rdata
);
    import dnsd_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Write the loaded byte and read the addressed byte every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dns_name_decompressor.sv =====
// ============================================================================
// DNS name decompressor
// Walks labels and compression pointers of a stored message, emits the name.
// ============================================================================
// A load word leaves the sequencer idle; the block is ready again in the next cycle.
// After a decode word is taken the block stays busy while it walks every label (its dot
// and characters), every followed pointer and the ending zero byte, and sends the last word.
// Results are held in an output register; a stalled result delays the walk.
// Reset is synchronous: the sequencer returns to idle and the hop limit to 8.
module dns_name_decompressor #(
    parameter int PACKET_BYTES     = 512,
    parameter int MAX_NAME_CHARS   = 255,
    parameter int CHARS_PER_RESULT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write channel.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dnsd_pkg::HOPS_W-1:0] i_cfg_data,
    // Input word channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [dnsd_pkg::ADDR_W-1:0] i_address,
    input  logic [dnsd_pkg::BYTE_W-1:0] i_data_byte,
    // Result word channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [dnsd_pkg::CHARS_W-1:0] o_name_chars,
    output logic [dnsd_pkg::CNT_W-1:0]  o_char_count,
    output logic                        o_last,
    output logic [dnsd_pkg::NOFF_W-1:0] o_next_offset,
    output logic [dnsd_pkg::LEN_W-1:0]  o_name_len,
    output logic [dnsd_pkg::ST_W-1:0]   o_status
);
    import dnsd_pkg::*;

    localparam int AW     = $clog2(PACKET_BYTES);
    localparam int PB_W   = $clog2(PACKET_BYTES + 1);
    localparam int POS_W  = (PB_W > PTR_W) ? PB_W : PTR_W;
    localparam logic [POS_W-1:0] POS_END   = POS_W'(PACKET_BYTES);
    localparam logic [LEN_W-1:0] NAME_MAX  = LEN_W'(MAX_NAME_CHARS);
    localparam logic [CNT_W-1:0] WORD_FULL = CNT_W'(CHARS_PER_RESULT);

    // Sequencer and datapath registers.
    t_step              r_step, n_step;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [NOFF_W-1:0]  r_resume, n_resume;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [HOPS_W-1:0]  r_hops, n_hops;
    logic [CHARS_W-1:0] r_pack, n_pack;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [5:0]         r_rem, n_rem;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic [ST_W-1:0]    r_status, n_status;
    logic [HOPS_W-1:0]  r_max_hops;

    // Output register.
    logic               r_out_valid;
    logic [CHARS_W-1:0] r_out_chars;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_last;
    logic [NOFF_W-1:0]  r_out_next;
    logic [LEN_W-1:0]   r_out_len;
    logic [ST_W-1:0]    r_out_status;

    t_uword             uw;
    t_br                br;
    logic               in_acc;
    logic               out_free;
    logic               push_flush;
    logic               push_last;
    logic               store_we;
    logic [POS_W-1:0]   addr_ext;
    logic [BYTE_W-1:0]  rdata;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_step != STEP_IDLE);
    assign o_cfg_ready = 1'b1;
    assign addr_ext   = POS_W'(i_address);
    assign store_we   = in_acc && (i_command == CMD_LOAD) && (addr_ext < POS_END);
    assign uw         = ucode(r_step);

    // Message store; the read address follows the next read position so that
    // the read data always matches the current position.
    dnsd_store #(
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (addr_ext[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (n_pos[AW-1:0]),
        .o_rdata (rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_IDLE;
            r_max_hops <= HOPS_RESET;
        end else begin
            r_step <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_hops <= i_cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_resume <= n_resume;
        r_count  <= n_count;
        r_hops   <= n_hops;
        r_pack   <= n_pack;
        r_fill   <= n_fill;
        r_rem    <= n_rem;
        r_byte   <= n_byte;
        r_status <= n_status;
    end

    // Datapath actions under the current control word, and branch selection.
    always_comb begin
        logic [POS_W-1:0]  pos_inc;
        logic              pos_oob;
        logic              name_full;
        logic              need_flush;
        logic              do_add;
        logic [BYTE_W-1:0] ch;

        pos_inc    = r_pos + POS_W'(1);
        pos_oob    = (r_pos >= POS_END);
        name_full  = (r_count >= NAME_MAX);
        need_flush = (r_fill >= WORD_FULL);
        do_add     = 1'b0;
        ch         = DOT_CHAR;

        n_pos      = r_pos;
        n_resume   = r_resume;
        n_count    = r_count;
        n_hops     = r_hops;
        n_pack     = r_pack;
        n_fill     = r_fill;
        n_rem      = r_rem;
        n_byte     = r_byte;
        n_status   = r_status;
        push_flush = 1'b0;
        push_last  = 1'b0;
        br         = BR_NEXT;

        case (uw.act)
            ACT_WAIT_CMD: begin
                br = BR_HOLD;
                if (in_acc && (i_command == CMD_DECODE)) begin
                    n_pos    = addr_ext;
                    n_resume = '0;
                    n_count  = '0;
                    n_hops   = '0;
                    n_pack   = '0;
                    n_fill   = '0;
                    n_rem    = '0;
                    n_status = ST_OK;
                    br       = BR_NEXT;
                end
            end
            ACT_PARSE_LEN: begin
                n_byte = rdata;
                if (pos_oob) begin
                    n_status = ST_RANGE;
                    br       = BR_STOP;
                end else if (rdata == '0) begin
                    // End of name: the offset is recorded only before any hop.
                    if (r_hops == '0) begin
                        n_resume = pos_inc[NOFF_W-1:0];
                    end
                    n_status = ST_OK;
                    br       = BR_STOP;
                end else if ((rdata & TYPE_MASK) == TYPE_MASK) begin
                    // Compression pointer.
                    if (r_hops >= r_max_hops) begin
                        n_status = ST_HOPS;
                        br       = BR_STOP;
                    end else if (pos_inc >= POS_END) begin
                        n_status = ST_RANGE;
                        br       = BR_STOP;
                    end else begin
                        if (r_hops == '0) begin
                            n_resume = NOFF_W'(pos_inc + POS_W'(1));
                        end
                        n_hops = r_hops + HOPS_W'(1);
                        n_pos  = pos_inc;
                        br     = BR_ALT;
                    end
                end else if ((rdata & TYPE_MASK) != '0) begin
                    n_status = ST_RESERVED;
                    br       = BR_STOP;
                end else begin
                    n_rem = 6'(rdata & LEN_MASK);
                    n_pos = pos_inc;
                    br    = BR_NEXT;
                end
            end
            ACT_LOAD_PTR: begin
                n_pos = POS_W'({6'(r_byte & LEN_MASK), rdata});
                br    = BR_NEXT;
            end
            ACT_EMIT_DOT: begin
                // A dot separates labels but never leads the name.
                if (r_count == '0) begin
                    br = BR_NEXT;
                end else if (name_full) begin
                    n_status = ST_LONG;
                    br       = BR_STOP;
                end else if (need_flush && !out_free) begin
                    br = BR_HOLD;
                end else begin
                    do_add = 1'b1;
                    br     = BR_NEXT;
                end
            end
            ACT_EMIT_CHAR: begin
                ch = rdata;
                if (r_rem == '0) begin
                    br = BR_NEXT;
                end else if (pos_oob) begin
                    n_status = ST_RANGE;
                    br       = BR_STOP;
                end else if (name_full) begin
                    n_status = ST_LONG;
                    br       = BR_STOP;
                end else if (need_flush && !out_free) begin
                    br = BR_HOLD;
                end else begin
                    do_add = 1'b1;
                    n_pos  = pos_inc;
                    n_rem  = r_rem - 6'd1;
                    br     = BR_HOLD;
                end
            end
            ACT_EMIT_LAST: begin
                if (out_free) begin
                    push_last = 1'b1;
                    br        = BR_NEXT;
                end else begin
                    br = BR_HOLD;
                end
            end
            default: begin
                br = BR_NEXT;
            end
        endcase

        // Append one character to the packing word, flushing a full word first.
        if (do_add) begin
            if (need_flush) begin
                push_flush = 1'b1;
                n_pack     = CHARS_W'(ch);
                n_fill     = CNT_W'(1);
            end else begin
                for (int i = 0; i < LANES; i++) begin
                    if (r_fill == CNT_W'(i)) begin
                        n_pack[8*i +: 8] = ch;
                    end
                end
                n_fill = r_fill + CNT_W'(1);
            end
            n_count = r_count + LEN_W'(1);
        end

        // Step counter update.
        case (br)
            BR_HOLD: n_step = r_step;
            BR_NEXT: n_step = uw.nxt;
            BR_ALT:  n_step = uw.alt;
            BR_STOP: n_step = uw.stp;
            default: n_step = STEP_IDLE;
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_flush || push_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (push_flush || push_last) begin
            r_out_chars  <= r_pack;
            r_out_count  <= r_fill;
            r_out_last   <= push_last;
            r_out_next   <= (push_last && (r_status == ST_OK)) ? r_resume : '0;
            r_out_len    <= push_last ? r_count : '0;
            r_out_status <= push_last ? r_status : ST_OK;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_name_chars  = r_out_chars;
    assign o_char_count  = r_out_count;
    assign o_last        = r_out_last;
    assign o_next_offset = r_out_next;
    assign o_name_len    = r_out_len;
    assign o_status      = r_out_status;

    // A result that is not the last one always carries a full word.
    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_char_count == WORD_FULL))
        else $error("partial word before the last result");

    // An error result never reports a resume offset.
    a_err_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_next_offset == '0))
        else $error("resume offset on an error result");

    // The walk never follows more pointers than the limit allows.
    a_hop_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_IDLE) |-> (r_hops <= r_max_hops))
        else $error("hop count above limit");

    // An accepted decode word makes the block busy in the next cycle.
    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_DECODE)) |=> o_in_stall)
        else $error("decode did not start");

endmodule

// ===== verif/dnsd_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// DNS name decompressor result checker
// Keeps a copy of the packet store and of the hop limit from the accepted
// words. Each decode word is walked here to get the name words it must
// produce. Every accepted result word is compared with the oldest of them.
// ============================================================================
module dnsd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [dnsd_pkg::HOPS_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_command,
    input  logic [dnsd_pkg::ADDR_W-1:0]  i_address,
    input  logic [dnsd_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [dnsd_pkg::CHARS_W-1:0] i_name_chars,
    input  logic [dnsd_pkg::CNT_W-1:0]   i_char_count,
    input  logic                         i_last,
    input  logic [dnsd_pkg::NOFF_W-1:0]  i_next_offset,
    input  logic [dnsd_pkg::LEN_W-1:0]   i_name_len,
    input  logic [dnsd_pkg::ST_W-1:0]    i_status,
    output int                           o_fail_count,
    output int                           o_pending
);
    import dnsd_pkg::*;

    localparam int STORE_BYTES = 512;
    localparam int NAME_MAX    = 255;
    localparam int REPORT_MAX  = 10;

    // One result word as the block sends it.
    typedef struct packed {
        logic [CHARS_W-1:0] chars;
        logic [CNT_W-1:0]   count;
        logic               last;
        logic [NOFF_W-1:0]  next_offset;
        logic [LEN_W-1:0]   name_len;
        logic [ST_W-1:0]    status;
    } t_name_word;

    logic [BYTE_W-1:0]  store_copy [STORE_BYTES];
    logic [HOPS_W-1:0]  hop_limit;
    t_name_word         expected_words [$];
    logic [CHARS_W-1:0] word_chars;
    int unsigned        word_fill;
    int unsigned        name_chars_seen;
    int                 fail_count = 0;

    // Appends one character to the word being packed. A full word is sent
    // out first. Returns 0 when the name would grow past its maximum length.
    function automatic bit add_name_char(input logic [BYTE_W-1:0] c);
        t_name_word w;
        if (name_chars_seen >= NAME_MAX)
            return 1'b0;
        if (word_fill >= LANES) begin
            w             = '0;
            w.chars       = word_chars;
            w.count       = CNT_W'(word_fill);
            w.status      = ST_OK;
            expected_words.push_back(w);
            word_chars = '0;
            word_fill  = 0;
        end
        word_chars[8*word_fill +: 8] = c;
        word_fill++;
        name_chars_seen++;
        return 1'b1;
    endfunction

    // Walks the name at the start offset and queues every word it yields.
    function automatic void predict_decode(input logic [ADDR_W-1:0] start);
        int unsigned       pos;
        int unsigned       resume;
        int unsigned       hops;
        int unsigned       remain;
        logic [BYTE_W-1:0] b;
        logic [ST_W-1:0]   st;
        bit                done;
        t_name_word        w;
        pos             = 32'(start);
        resume          = 0;
        hops            = 0;
        st              = ST_OK;
        done            = 1'b0;
        word_chars      = '0;
        word_fill       = 0;
        name_chars_seen = 0;
        while (!done) begin
            if (pos >= STORE_BYTES) begin
                st   = ST_RANGE;
                done = 1'b1;
            end else begin
                b = store_copy[ADDR_W'(pos)];
                if (b == 8'h00) begin
                    // The resume offset is taken only before the first pointer.
                    if (hops == 0)
                        resume = pos + 1;
                    done = 1'b1;
                end else if ((b & TYPE_MASK) == TYPE_MASK) begin
                    if (hops >= hop_limit) begin
                        st   = ST_HOPS;
                        done = 1'b1;
                    end else if (pos + 1 >= STORE_BYTES) begin
                        st   = ST_RANGE;
                        done = 1'b1;
                    end else begin
                        if (hops == 0)
                            resume = pos + 2;
                        hops++;
                        pos = (32'(b & LEN_MASK) << 8) | 32'(store_copy[ADDR_W'(pos + 1)]);
                    end
                end else if ((b & TYPE_MASK) != 8'h00) begin
                    st   = ST_RESERVED;
                    done = 1'b1;
                end else begin
                    // Plain label: a dot between labels, then its characters.
                    remain = 32'(b);
                    pos++;
                    if (name_chars_seen > 0 && !add_name_char(DOT_CHAR)) begin
                        st   = ST_LONG;
                        done = 1'b1;
                    end
                    while (!done && remain > 0) begin
                        if (pos >= STORE_BYTES) begin
                            st   = ST_RANGE;
                            done = 1'b1;
                        end else if (!add_name_char(store_copy[ADDR_W'(pos)])) begin
                            st   = ST_LONG;
                            done = 1'b1;
                        end else begin
                            pos++;
                            remain--;
                        end
                    end
                end
            end
        end
        w             = '0;
        w.chars       = word_chars;
        w.count       = CNT_W'(word_fill);
        w.last        = 1'b1;
        w.next_offset = (st == ST_OK) ? NOFF_W'(resume) : '0;
        w.name_len    = LEN_W'(name_chars_seen);
        w.status      = st;
        expected_words.push_back(w);
    endfunction

    function automatic void report_field(input string field,
                                         input logic [CHARS_W-1:0] want,
                                         input logic [CHARS_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
    endfunction

    // Configuration and input words are taken before result words, so a
    // decode is predicted before any of its words can be compared.
    always @(posedge i_clk) begin : watch
        t_name_word got;
        t_name_word want;
        if (!i_rst_n) begin
            hop_limit = HOPS_RESET;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                hop_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (i_command == CMD_LOAD)
                    store_copy[i_address] = i_data_byte;
                else
                    predict_decode(i_address);
            end
            if ($isunknown(i_out_valid)) begin
                report_field("out_valid", '0, {63'd0, i_out_valid});
            end else if (i_out_valid && !i_out_stall) begin
                got.chars       = i_name_chars;
                got.count       = i_char_count;
                got.last        = i_last;
                got.next_offset = i_next_offset;
                got.name_len    = i_name_len;
                got.status      = i_status;
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result word with none expected, chars 0x%0h",
                                 $time, got.chars);
                end else begin
                    want = expected_words.pop_front();
                    if (got.chars !== want.chars)
                        report_field("name_chars", want.chars, got.chars);
                    if (got.count !== want.count)
                        report_field("char_count", CHARS_W'(want.count),
                                     CHARS_W'(got.count));
                    if (got.last !== want.last)
                        report_field("last", CHARS_W'(want.last), CHARS_W'(got.last));
                    if (got.next_offset !== want.next_offset)
                        report_field("next_offset", CHARS_W'(want.next_offset),
                                     CHARS_W'(got.next_offset));
                    if (got.name_len !== want.name_len)
                        report_field("name_len", CHARS_W'(want.name_len),
                                     CHARS_W'(got.name_len));
                    if (got.status !== want.status)
                        report_field("status", CHARS_W'(want.status),
                                     CHARS_W'(got.status));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_words.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// DNS name decompressor testbench
// Loads a directed set of names and special cases, then builds short random
// names, pointer chains and broken names in free store space under several
// hop limits, with idle gaps on the input channel and stall bursts on the result channel.
// ============================================================================
module tb_top;
    import dnsd_pkg::*;

    localparam int STORE_BYTES      = 512;
    localparam int SETTLE_CYCLES    = 20;
    localparam int NAMES_PER_PHASE  = 3;
    localparam int HOP_PHASES       = 5;
    localparam int STARTS_KEPT      = 16;
    localparam int LOOP_BASE        = 8;
    localparam int LOOP_LABEL       = 10;
    localparam int FRAG_BASE        = 32;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [HOPS_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   data_byte;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CHARS_W-1:0]  name_chars;
    logic [CNT_W-1:0]    char_count;
    logic                last;
    logic [NOFF_W-1:0]   next_offset;
    logic [LEN_W-1:0]    name_len;
    logic [ST_W-1:0]     status;
    int                  fail_count;
    int                  pending;
    bit                  idle_en = 1'b1;
    int                  stall_left = 0;
    int                  next_free;
    int                  name_starts [$];
    logic [BYTE_W-1:0]   msg [$];
    logic [HOPS_W-1:0]   hop_settings [HOP_PHASES];

    dns_name_decompressor u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_address     (address),
        .i_data_byte   (data_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_name_chars  (name_chars),
        .o_char_count  (char_count),
        .o_last        (last),
        .o_next_offset (next_offset),
        .o_name_len    (name_len),
        .o_status      (status)
    );

    dnsd_checker u_name_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_address     (address),
        .i_data_byte   (data_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_name_chars  (name_chars),
        .i_char_count  (char_count),
        .i_last        (last),
        .i_next_offset (next_offset),
        .i_name_len    (name_len),
        .i_status      (status),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung run.
    initial begin
        #25_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Result back-pressure in random bursts.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall = 1'b1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            out_stall  = 1'b1;
        end else begin
            out_stall = 1'b0;
        end
    end

    // Presents one input word and returns once it is accepted. Valid stays
    // high so that the next word can follow without a gap.
    task automatic send_word(input logic cmd, input int addr,
                             input logic [BYTE_W-1:0] value);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        in_valid  = 1'b1;
        command   = cmd;
        address   = ADDR_W'(addr);
        data_byte = value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stops sending and waits until every predicted name word has come.
    task automatic wait_names_done();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_hop_limit(input logic [HOPS_W-1:0] value);
        wait_names_done();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic void add_label(input int len);
        msg.push_back(BYTE_W'(len));
        repeat (len) msg.push_back(BYTE_W'($urandom_range(0, 255)));
    endfunction

    function automatic void add_pointer(input int target);
        msg.push_back(TYPE_MASK | (BYTE_W'(target >> 8) & LEN_MASK));
        msg.push_back(BYTE_W'(target));
    endfunction

    // Builds one random fragment in free store space, loads it, and decodes
    // it, or decodes a name that is already stored. Fragments never overlap,
    // so every walk stays on written entries.
    task automatic random_name_item();
        int kind;
        int base;
        int hops;
        bit reuse;
        msg.delete();
        kind  = $urandom_range(0, 99);
        base  = next_free;
        reuse = (kind < 30) && (name_starts.size() > 0);
        if (reuse) begin
            base = name_starts[$urandom_range(0, name_starts.size() - 1)];
        end else if (kind < 65) begin
            // Well-formed name, ended by a zero or by a pointer to an earlier name.
            repeat ($urandom_range(1, 2)) add_label($urandom_range(1, 3));
            if (name_starts.size() > 0 && $urandom_range(0, 2) == 0)
                add_pointer(name_starts[$urandom_range(0, name_starts.size() - 1)]);
            else
                msg.push_back(8'h00);
        end else if (kind < 88) begin
            // Chain of pointers, each to the next slot, to probe the hop limit.
            hops = $urandom_range(0, 4);
            for (int i = 0; i < hops; i++)
                add_pointer(base + 2 * (i + 1));
            add_label($urandom_range(1, 3));
            msg.push_back(8'h00);
        end else begin
            // Name broken by a reserved label type.
            add_label($urandom_range(1, 3));
            msg.push_back(BYTE_W'($urandom_range(8'h40, 8'hBF)));
        end

        foreach (msg[i])
            send_word(CMD_LOAD, base + i, msg[i]);
        next_free += msg.size();

        if (!reuse && kind < 88) begin
            name_starts.push_back(base);
            if (name_starts.size() > STARTS_KEPT)
                void'(name_starts.pop_front());
        end

        // Now and then let the block run empty before the next decode.
        if ($urandom_range(0, 7) == 0)
            wait_names_done();
        send_word(CMD_DECODE, base, BYTE_W'($urandom_range(0, 255)));
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        command   = CMD_LOAD;
        address   = '0;
        data_byte = '0;
        next_free = FRAG_BASE;
        hop_settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd8};
        hop_settings[HOP_PHASES - 1] = HOPS_W'($urandom_range(2, 15));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases at the reset hop limit.
        // Root name at the first entry.
        send_word(CMD_LOAD, 0, 8'h00);
        send_word(CMD_DECODE, 0, 8'hFF);
        // Reserved label types at both ends of their range.
        send_word(CMD_LOAD, 1, 8'h40);
        send_word(CMD_DECODE, 1, 8'h00);
        send_word(CMD_LOAD, 2, 8'hBF);
        send_word(CMD_DECODE, 2, 8'h00);
        // Pointer whose target lies far beyond the store.
        send_word(CMD_LOAD, 3, 8'hFF);
        send_word(CMD_LOAD, 4, 8'hFF);
        send_word(CMD_DECODE, 3, 8'h00);
        // Pointer to itself runs into the hop limit.
        send_word(CMD_LOAD, 5, 8'hC0);
        send_word(CMD_LOAD, 6, 8'h05);
        send_word(CMD_DECODE, 5, 8'h00);
        // Pointer in the last two entries to the root name.
        send_word(CMD_LOAD, STORE_BYTES - 2, 8'hC0);
        send_word(CMD_LOAD, STORE_BYTES - 1, 8'h00);
        send_word(CMD_DECODE, STORE_BYTES - 2, 8'h00);
        // Label that runs off the end of the store.
        send_word(CMD_LOAD, STORE_BYTES - 4, 8'h05);
        send_word(CMD_LOAD, STORE_BYTES - 3, 8'h61);
        send_word(CMD_DECODE, STORE_BYTES - 4, 8'h00);
        // Pointer whose second byte would lie beyond the store.
        send_word(CMD_LOAD, STORE_BYTES - 1, 8'hC0);
        send_word(CMD_DECODE, STORE_BYTES - 1, 8'h00);
        // A label followed by a pointer back to it repeats without end.
        msg.delete();
        add_label(LOOP_LABEL);
        add_pointer(LOOP_BASE);
        foreach (msg[i])
            send_word(CMD_LOAD, LOOP_BASE + i, msg[i]);
        send_word(CMD_DECODE, LOOP_BASE, 8'h00);

        // Random names under several hop limits; the last phase runs without idling.
        for (int p = 0; p < HOP_PHASES; p++) begin
            set_hop_limit(hop_settings[p]);
            idle_en = (p < HOP_PHASES - 1);
            // The repeating name stops at the hop limit or, at high limits, by length.
            send_word(CMD_DECODE, LOOP_BASE, 8'h00);
            for (int n = 0; n < NAMES_PER_PHASE; n++) begin
                idle_en = (p < HOP_PHASES - 1) && ($urandom_range(0, 3) != 0);
                random_name_item();
            end
        end

        wait_names_done();
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
